FILE: hw/rtl/bid_pkg.sv
`timescale 1ns / 1ps

package bid_pkg;

  // Number of ring slots. Any value from two to 127 fits the count field; the ring wraps by compare.
  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned AW1   = AW + 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = 32;
  localparam int unsigned OPW   = 3;
  localparam int unsigned POSW  = 6;
  localparam int unsigned CNTW  = 7;

  localparam logic [DW-1:0] EMPTY_MARK = '1;

  typedef enum logic [OPW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } memreq_t;

  // A field flagged as coming from memory is replaced by the RAM read data
  // in the cycle the result is shown.
  typedef struct packed {
    status_e         status;
    logic [DW-1:0]   front;
    logic [DW-1:0]   back;
    logic [DW-1:0]   elem;
    logic [CNTW-1:0] count;
    logic [DW-1:0]   total;
    logic            front_mem;
    logic            back_mem;
    logic            elem_mem;
  } result_t;

  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW1-1:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= AW1'(DEPTH)) begin
      s = s - AW1'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_dec(logic [AW-1:0] base);
    logic [AW-1:0] r;
    if (base == '0) begin
      r = AW'(DEPTH - 1);
    end else begin
      r = base - 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/bounded_int_deque_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// command   in         start_i, busy_o           operation_i, push_value_i, position_i
// result    out        done_o (one-cycle strobe) status_o, front_value_o, back_value_o,
//                                                element_value_o, element_count_o, total_o
//
// One item is taken in every cycle; busy_o is never raised.
// The result of an item is shown for exactly one cycle, the cycle after the item
// is accepted, and the rate is one item per cycle.
// That cycle is set by the ring RAM, whose read data is registered.
// Reset clears the ring pointer, the element count and the running sum at once.
// The receiver cannot stall; a result is gone after its strobe cycle.

module bounded_int_deque_unit import bid_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [OPW-1:0]         operation_i,
  input  logic signed [DW-1:0]   push_value_i,
  input  logic [POSW-1:0]        position_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic signed [DW-1:0]   front_value_o,
  output logic signed [DW-1:0]   back_value_o,
  output logic signed [DW-1:0]   element_value_o,
  output logic [CNTW-1:0]        element_count_o,
  output logic signed [DW-1:0]   total_o
);

  logic          accept;
  memreq_t       mem_req;
  logic [DW-1:0] rdata;
  result_t       res_d, res_q;
  logic          done_q;

  // Every operation finishes in a single pass, so the unit never pushes back.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Pointer, count and sum bookkeeping, plus the cached front and back values.
  bid_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (operation_i),
    .value_i  (push_value_i),
    .pos_i    (position_i),
    .rdata_i  (rdata),
    .mem_o    (mem_req),
    .res_o    (res_d)
  );

  // The ring storage. Only slots that hold an element are ever read.
  bid_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // Result register. Fields that depend on a slot read are completed from the
  // RAM output, which becomes valid in the same cycle the result is shown.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o          = done_q;
  assign status_o        = res_q.status;
  assign front_value_o   = res_q.front_mem ? rdata : res_q.front;
  assign back_value_o    = res_q.back_mem ? rdata : res_q.back;
  assign element_value_o = res_q.elem_mem ? rdata : res_q.elem;
  assign element_count_o = res_q.count;
  assign total_o         = res_q.total;

endmodule

FILE: hw/rtl/bid_ram.sv
`timescale 1ns / 1ps

module bid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bid_ctrl.sv
`timescale 1ns / 1ps

module bid_ctrl import bid_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [OPW-1:0]  op_i,
  input  logic [DW-1:0]   value_i,
  input  logic [POSW-1:0] pos_i,
  input  logic [DW-1:0]   rdata_i,
  output memreq_t         mem_o,
  output result_t         res_o
);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] sum_q, sum_d;
  logic [DW-1:0] front_q, front_d, back_q, back_d;
  logic          fpend_q, fpend_d, bpend_q, bpend_d;
  logic [DW-1:0] front_cur, back_cur;
  status_e       status;
  logic          elem_mem;

  // The cached end values are stale in the cycle after a pop that reads the RAM;
  // the RAM read data then holds the true value.
  assign front_cur = fpend_q ? rdata_i : front_q;
  assign back_cur  = bpend_q ? rdata_i : back_q;

  always_comb begin
    head_d   = head_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    front_d  = front_cur;
    back_d   = back_cur;
    fpend_d  = 1'b0;
    bpend_d  = 1'b0;
    mem_o    = '0;
    status   = ST_OK;
    elem_mem = 1'b0;
    if (accept_i) begin
      case (op_e'(op_i))
        OP_PUSH_FRONT: begin
          if (cnt_q >= CW'(DEPTH)) begin
            status = ST_FULL;
          end else begin
            head_d      = ring_dec(head_q);
            mem_o.we    = 1'b1;
            mem_o.waddr = ring_dec(head_q);
            mem_o.wdata = value_i;
            front_d     = value_i;
            if (cnt_q == '0) begin
              back_d = value_i;
            end
            cnt_d = cnt_q + 1'b1;
            sum_d = sum_q + value_i;
          end
        end
        OP_PUSH_BACK: begin
          if (cnt_q >= CW'(DEPTH)) begin
            status = ST_FULL;
          end else begin
            mem_o.we    = 1'b1;
            mem_o.waddr = ring_add(head_q, AW'(cnt_q));
            mem_o.wdata = value_i;
            back_d      = value_i;
            if (cnt_q == '0) begin
              front_d = value_i;
            end
            cnt_d = cnt_q + 1'b1;
            sum_d = sum_q + value_i;
          end
        end
        OP_POP_FRONT: begin
          if (cnt_q == '0) begin
            status = ST_EMPTY;
          end else begin
            sum_d  = sum_q - front_cur;
            head_d = ring_add(head_q, AW'(1));
            cnt_d  = cnt_q - 1'b1;
            if (cnt_q > CW'(1)) begin
              mem_o.re    = 1'b1;
              mem_o.raddr = ring_add(head_q, AW'(1));
              fpend_d     = 1'b1;
            end
          end
        end
        OP_POP_BACK: begin
          if (cnt_q == '0) begin
            status = ST_EMPTY;
          end else begin
            sum_d = sum_q - back_cur;
            cnt_d = cnt_q - 1'b1;
            if (cnt_q > CW'(1)) begin
              mem_o.re    = 1'b1;
              mem_o.raddr = ring_add(head_q, AW'(cnt_q - CW'(2)));
              bpend_d     = 1'b1;
            end
          end
        end
        OP_READ: begin
          if (32'(pos_i) >= 32'(cnt_q)) begin
            status = ST_RANGE;
          end else begin
            mem_o.re    = 1'b1;
            mem_o.raddr = ring_add(head_q, AW'(pos_i));
            elem_mem    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o.status    = status;
    res_o.front     = (cnt_d == '0) ? EMPTY_MARK : front_d;
    res_o.back      = (cnt_d == '0) ? EMPTY_MARK : back_d;
    res_o.elem      = '0;
    res_o.count     = CNTW'(cnt_d);
    res_o.total     = sum_d;
    res_o.front_mem = fpend_d;
    res_o.back_mem  = bpend_d;
    res_o.elem_mem  = elem_mem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      fpend_q <= 1'b0;
      bpend_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      fpend_q <= fpend_d;
      bpend_q <= bpend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
  end

endmodule

FILE: hw/rtl/bid_checker.sv
`timescale 1ns / 1ps

module bid_checker import bid_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start_i,
  input logic                 busy_o,
  input logic [OPW-1:0]       operation_i,
  input logic signed [DW-1:0] push_value_i,
  input logic [POSW-1:0]      position_i,
  input logic                 done_o,
  input logic [1:0]           status_o,
  input logic signed [DW-1:0] front_value_o,
  input logic signed [DW-1:0] back_value_o,
  input logic signed [DW-1:0] element_value_o,
  input logic [CNTW-1:0]      element_count_o,
  input logic signed [DW-1:0] total_o
);

  // Every accepted item yields its result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> done_o)
    else $error("accepted item produced no result");

  // A pop on an empty queue leaves nothing behind.
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_EMPTY |-> element_count_o == '0 &&
      front_value_o == EMPTY_MARK && back_value_o == EMPTY_MARK && total_o == '0)
    else $error("empty pop reported stored state");

  // An out-of-range read returns zero.
  a_range_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_RANGE |-> element_value_o == '0)
    else $error("out-of-range read returned data");

  // Back-to-back results: a rejected push keeps count and sum unchanged.
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(done_o) && status_o == ST_FULL |->
      element_count_o == $past(element_count_o) && total_o == $past(total_o))
    else $error("rejected push changed the queue");

  // A single stored element is both the front and the back.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && element_count_o == CNTW'(1) && CW'(DEPTH) != CW'(0) |->
      front_value_o == back_value_o)
    else $error("front and back differ with one element");

endmodule

bind bounded_int_deque_unit bid_checker u_bid_checker (.*);

FILE: tb/tb_bounded_int_deque_unit.sv
`timescale 1ns / 1ps

// Checks the bounded integer deque end to end. Every accepted command is run
// through a behavioral copy of the ring that lives in this module, and the
// result that the block strobes out is compared, field by field, with the
// oldest result still owed. A short table of hand-picked commands comes first,
// then phases of random commands that lean toward filling or draining the ring or mix both.
// This drives it through full, empty and wrapped states many times.
module tb_bounded_int_deque_unit;
  import bid_pkg::*;

  // The result fields of one command, in port order.
  typedef struct packed {
    status_e         status;
    logic [DW-1:0]   front;
    logic [DW-1:0]   back;
    logic [DW-1:0]   elem;
    logic [CNTW-1:0] count;
    logic [DW-1:0]   total;
  } deque_result_t;

  // One row of the directed table. When pinned is set, the typed-in result is
  // what the block must return. Otherwise the ring copy below decides.
  typedef struct packed {
    logic [OPW-1:0]  op;
    logic [DW-1:0]   value;
    logic [POSW-1:0] pos;
    logic            pinned;
    status_e         status;
    logic [DW-1:0]   front;
    logic [DW-1:0]   back;
    logic [DW-1:0]   elem;
    logic [CNTW-1:0] count;
    logic [DW-1:0]   total;
  } cmd_row_t;

  typedef enum int {
    PHASE_FILL,
    PHASE_DRAIN,
    PHASE_MIX
  } phase_e;

  // Operation codes past the last defined one. The block must treat them as
  // no-ops that still report the current state.
  localparam int OP_SPARE_LO  = int'(OP_READ) + 1;
  localparam int OP_SPARE_HI  = (1 << OPW) - 1;
  localparam int POS_MAX      = (1 << POSW) - 1;
  localparam int MAX_GAP      = 11;
  localparam int RANDOM_ITEMS = 900;
  localparam int N_DIRECTED   = 24;
  localparam int REPORT_LIMIT = 10;

  localparam logic [DW-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [DW-1:0] MOST_POS = 32'h7FFF_FFFF;

  // The directed sequence walks from an empty ring through both extremes of
  // the value range, both ends of the position range, every operation and the
  // unused codes, and back down to empty. On the way down, the last element is
  // removed from the back. The rows whose result is plain from the state are
  // pinned.
  localparam cmd_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // Pops and a read on the empty ring right after reset.
    '{OP_POP_FRONT,  '0, '0, 1'b1, ST_EMPTY, EMPTY_MARK, EMPTY_MARK, '0, 7'd0, '0},
    '{OP_POP_BACK,   '0, '0, 1'b1, ST_EMPTY, EMPTY_MARK, EMPTY_MARK, '0, 7'd0, '0},
    '{OP_READ,       '0, '0, 1'b1, ST_RANGE, EMPTY_MARK, EMPTY_MARK, '0, 7'd0, '0},
    // The two signed extremes, one at each end; their sum is -1.
    '{OP_PUSH_BACK,  MOST_POS, '0, 1'b1, ST_OK, MOST_POS, MOST_POS, '0, 7'd1, MOST_POS},
    '{OP_PUSH_FRONT, MOST_NEG, '0, 1'b1, ST_OK, MOST_NEG, MOST_POS, '0, 7'd2, '1},
    '{OP_READ,       '0, 6'd0, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OP_READ,       '0, 6'd1, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    // The highest position is always out of range here.
    '{OP_READ,       '0, 6'd63, 1'b1, ST_RANGE, MOST_NEG, MOST_POS, '0, 7'd2, '1},
    '{OP_PUSH_BACK,  '1, '0, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OP_PUSH_FRONT, '0, '0, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OP_PUSH_BACK,  32'h5555_5555, '0, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OP_PUSH_FRONT, 32'hAAAA_AAAA, '0, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OP_READ,       '0, 6'd2, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OP_READ,       '0, 6'd5, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OP_POP_FRONT,  '0, '0, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OP_POP_BACK,   '0, '0, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OPW'(OP_SPARE_LO), 32'h1234_5678, 6'd3, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OPW'(OP_SPARE_HI), '1, '1, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OP_POP_FRONT,  '0, '0, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OP_POP_BACK,   '0, '0, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OP_POP_FRONT,  '0, '0, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    // A pop from the back that takes the only element.
    '{OP_POP_BACK,   '0, '0, 1'b1, ST_OK, EMPTY_MARK, EMPTY_MARK, '0, 7'd0, '0},
    '{OP_PUSH_FRONT, 32'h0000_1234, '0, 1'b0, ST_OK, '0, '0, '0, 7'd0, '0},
    '{OP_POP_FRONT,  '0, '0, 1'b1, ST_OK, EMPTY_MARK, EMPTY_MARK, '0, 7'd0, '0}
  };

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic [OPW-1:0]       operation_i = '0;
  logic signed [DW-1:0] push_value_i = '0;
  logic [POSW-1:0]      position_i = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [1:0]           status_o;
  logic signed [DW-1:0] front_value_o;
  logic signed [DW-1:0] back_value_o;
  logic signed [DW-1:0] element_value_o;
  logic [CNTW-1:0]      element_count_o;
  logic signed [DW-1:0] total_o;

  // A pinned result travels with the command that it belongs to.
  logic          cmd_pinned = 1'b0;
  deque_result_t cmd_pinned_res = '0;

  // Shadow of the ring: slots, index of the front slot, fill level, sum.
  logic [DW-1:0] ring_slot [DEPTH];
  int unsigned   ring_head = 0;
  int unsigned   ring_fill = 0;
  logic [DW-1:0] ring_sum = '0;

  deque_result_t owed_results [$];
  int            fault_count = 0;
  bit            no_idle = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bounded_int_deque_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .push_value_i    (push_value_i),
    .position_i      (position_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .front_value_o   (front_value_o),
    .back_value_o    (back_value_o),
    .element_value_o (element_value_o),
    .element_count_o (element_count_o),
    .total_o         (total_o)
  );

  // Applies one command to the shadow ring and returns what the block should
  // report for it. Only occupied slots are ever read, so the slots that have
  // never been written stay out of the picture.
  function automatic deque_result_t apply_command(input logic [OPW-1:0] op,
                                                  input logic [DW-1:0] value,
                                                  input logic [POSW-1:0] pos);
    deque_result_t res;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (ring_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            ring_slot[ring_head] = value;
          end else begin
            ring_slot[(ring_head + ring_fill) % DEPTH] = value;
          end
          ring_fill++;
          ring_sum = ring_sum + value;
        end
      end
      OP_POP_FRONT: begin
        if (ring_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          ring_sum = ring_sum - ring_slot[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
        end
      end
      OP_POP_BACK: begin
        if (ring_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          ring_sum = ring_sum - ring_slot[(ring_head + ring_fill - 1) % DEPTH];
          ring_fill--;
        end
      end
      OP_READ: begin
        if (pos >= ring_fill) begin
          res.status = ST_RANGE;
        end else begin
          res.elem = ring_slot[(ring_head + pos) % DEPTH];
        end
      end
      default: begin
      end
    endcase
    if (ring_fill == 0) begin
      res.front = EMPTY_MARK;
      res.back  = EMPTY_MARK;
    end else begin
      res.front = ring_slot[ring_head];
      res.back  = ring_slot[(ring_head + ring_fill - 1) % DEPTH];
    end
    res.count = CNTW'(ring_fill);
    res.total = ring_sum;
    return res;
  endfunction

  // Presents one command after a random number of idle cycles and returns at
  // the edge that accepts it. The start line is touched once per time step, so
  // back-to-back commands keep it high without a glitch.
  task automatic drive_command(input logic [OPW-1:0] op, input logic [DW-1:0] value,
                               input logic [POSW-1:0] pos, input logic pinned,
                               input deque_result_t pin_res);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    operation_i    <= op;
    push_value_i   <= value;
    position_i     <= pos;
    cmd_pinned     <= pinned;
    cmd_pinned_res <= pin_res;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Monitor. At each edge it first books the result owed by a command that is
  // accepted there, then matches any strobed result against the oldest one
  // owed. This order also holds if a result ever came in the cycle of its own
  // command. All values are read before the edge takes effect.
  always @(posedge clk_i) begin
    deque_result_t want;
    deque_result_t got;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        want = apply_command(operation_i, push_value_i, position_i);
        owed_results.insert(owed_results.size(), cmd_pinned ? cmd_pinned_res : want);
      end
      if (done_o) begin
        got = '{status_e'(status_o), front_value_o, back_value_o, element_value_o,
                element_count_o, total_o};
        if (owed_results.size() == 0) begin
          if (fault_count < REPORT_LIMIT) begin
            $display("%0t: result strobed with none owed", $realtime);
          end
          fault_count++;
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          if (got.status != want.status || got.front != want.front ||
              got.back != want.back || got.elem != want.elem ||
              got.count != want.count || got.total != want.total) begin
            if (fault_count < REPORT_LIMIT) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected status=%0d front=%h back=%h elem=%h count=%0d total=%h",
                       want.status, want.front, want.back, want.elem, want.count,
                       want.total);
              $display("  actual   status=%0d front=%h back=%h elem=%h count=%0d total=%h",
                       got.status, got.front, got.back, got.elem, got.count, got.total);
            end
            fault_count++;
          end
        end
      end
    end
  end

  // Stimulus and end of the run.
  initial begin
    phase_e          phase;
    int              phase_len;
    int              sent;
    int              waited;
    int              roll;
    int              push_pct;
    int              pop_pct;
    logic [OPW-1:0]  op;
    logic [DW-1:0]   value;
    logic [POSW-1:0] pos;
    deque_result_t   pin;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      pin = '{DIRECTED_ROWS[i].status, DIRECTED_ROWS[i].front, DIRECTED_ROWS[i].back,
              DIRECTED_ROWS[i].elem, DIRECTED_ROWS[i].count, DIRECTED_ROWS[i].total};
      drive_command(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].pos,
                    DIRECTED_ROWS[i].pinned, pin);
    end

    // Random phases. A fill phase mostly pushes and so runs the ring into its
    // full state and keeps pushing against it. A drain phase does the reverse.
    // About one phase in four runs with no idle cycles at all.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase     = phase_e'($urandom_range(0, 2));
      phase_len = $urandom_range(30, 120);
      no_idle   = ($urandom_range(0, 3) == 0);
      case (phase)
        PHASE_FILL: begin
          push_pct = 70;
          pop_pct  = 10;
        end
        PHASE_DRAIN: begin
          push_pct = 10;
          pop_pct  = 70;
        end
        default: begin
          push_pct = 35;
          pop_pct  = 35;
        end
      endcase
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else if (roll < push_pct + pop_pct) begin
          op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        end else if (roll < 95) begin
          op = OP_READ;
        end else begin
          op = OPW'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0: value = MOST_NEG;
            1: value = MOST_POS;
            2: value = '1;
            default: value = '0;
          endcase
        end else begin
          value = $urandom();
        end
        // Reads mostly land inside the ring. The fill level seen here may lag
        // by one command, which only shifts the bias.
        if (ring_fill > 0 && $urandom_range(0, 3) != 0) begin
          pos = POSW'($urandom_range(0, ring_fill - 1));
        end else begin
          pos = POSW'($urandom_range(0, POS_MAX));
        end
        drive_command(op, value, pos, 1'b0, '0);
        sent++;
      end
    end
    start_i <= 1'b0;

    // Give the last results time to come out, then keep watching
    // for anything the block should not send.
    waited = 0;
    while (owed_results.size() != 0 && waited < 64) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (owed_results.size() != 0) begin
      $display("%0d results never arrived", owed_results.size());
      fault_count += owed_results.size();
    end

    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // The slowest correct run takes well under 30 us.
  initial begin
    #200_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bid_pkg.sv
hw/rtl/bid_ram.sv
hw/rtl/bid_ctrl.sv
hw/rtl/bounded_int_deque_unit.sv
hw/rtl/bid_checker.sv
tb/tb_bounded_int_deque_unit.sv
